// ----- sv/pf_dec_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pf_dec_pkg
// Shared types, constants and letter helpers for the Playfair decryptor.
// ----------------------------------------------------------------------------
package pf_dec_pkg;

  localparam int unsigned LetterW = 5;
  localparam int unsigned CoordW  = 3;
  localparam int unsigned Side    = 5;
  localparam int unsigned Cells   = Side * Side;
  localparam int unsigned Alpha   = 26;

  localparam logic [LetterW-1:0] LetterI    = 5'd8;
  localparam logic [LetterW-1:0] LetterJ    = 5'd9;
  localparam logic [LetterW-1:0] LetterZ    = 5'd25;
  localparam logic [LetterW-1:0] CellsCode  = 5'(Cells);
  localparam logic [CoordW-1:0]  SideLast   = 3'(Side - 1);

  typedef enum logic {
    MODE_KEY  = 1'b0,
    MODE_PAIR = 1'b1
  } mode_t;

  typedef struct packed {
    logic               mode;
    logic [LetterW-1:0] first_letter;
    logic [LetterW-1:0] second_letter;
  } pf_in_t;

  typedef struct packed {
    logic [LetterW-1:0] plain_first;
    logic [LetterW-1:0] plain_second;
  } pf_out_t;

  typedef struct packed {
    logic key_write;
    logic latch;
    logic pos_read_in;
    logic fill_step;
    logic pos_read_lat;
    logic cell_read;
  } pf_cmd_t;

  typedef struct packed {
    logic complete;
    logic fill_last;
  } pf_stat_t;

  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
  } pf_pos_t;

  function automatic logic [LetterW-1:0] norm_letter(input logic [LetterW-1:0] l);
    logic [LetterW-1:0] v;
    v = (l > LetterZ) ? LetterZ : l;
    if (v == LetterJ) begin
      v = LetterI;
    end
    return v;
  endfunction

  function automatic logic [CoordW-1:0] dec_wrap(input logic [CoordW-1:0] v);
    return (v == '0) ? SideLast : v - 3'd1;
  endfunction

  function automatic logic [LetterW-1:0] cell_index(input logic [CoordW-1:0] r,
                                                    input logic [CoordW-1:0] c);
    return ({2'b00, r} << 2) + {2'b00, r} + {2'b00, c};
  endfunction

endpackage

// ----- sv/pf_dec_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pf_dec_ctrl
// Sequencer: accepts items, runs the square fill and the pair lookup.
// ----------------------------------------------------------------------------
module pf_dec_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                mode,
  input  pf_dec_pkg::pf_stat_t stat,
  output logic                busy,
  output pf_dec_pkg::pf_cmd_t  cmd
);
  import pf_dec_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FILL = 4'b0010,
    S_POS  = 4'b0100,
    S_CELL = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (mode == MODE_PAIR)) begin
          state_next = stat.complete ? S_CELL : S_FILL;
        end
      end
      S_FILL: begin
        if (stat.fill_last) begin
          state_next = S_POS;
        end
      end
      S_POS:   state_next = S_CELL;
      S_CELL:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd              = '0;
    cmd.key_write    = accept && (mode == MODE_KEY) && !stat.complete;
    cmd.latch        = accept && (mode == MODE_PAIR);
    cmd.pos_read_in  = accept && (mode == MODE_PAIR) && stat.complete;
    cmd.fill_step    = (state == S_FILL);
    cmd.pos_read_lat = (state == S_POS);
    cmd.cell_read    = (state == S_CELL);
  end

endmodule

// ----- sv/pf_dec_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pf_dec_dp
// Datapath: key square and position memories, fill walk, pair lookup.
// ----------------------------------------------------------------------------
module pf_dec_dp (
  input  logic                clk,
  input  logic                rst,
  input  pf_dec_pkg::pf_in_t   item,
  input  pf_dec_pkg::pf_cmd_t  cmd,
  output pf_dec_pkg::pf_stat_t stat,
  output logic                done,
  output pf_dec_pkg::pf_out_t  result
);
  import pf_dec_pkg::*;

  logic [LetterW-1:0] sq_mem  [Cells];
  pf_pos_t            pos_mem [Alpha];

  logic [Alpha-1:0]   used;
  logic [LetterW-1:0] fill_count;
  logic [CoordW-1:0]  fill_row;
  logic [CoordW-1:0]  fill_col;
  logic               complete;
  logic [LetterW-1:0] walk;
  logic [LetterW-1:0] a_lat;
  logic [LetterW-1:0] b_lat;
  pf_pos_t            pos1;
  pf_pos_t            pos2;

  logic [LetterW-1:0] in_a;
  logic [LetterW-1:0] in_b;
  logic [LetterW-1:0] place_letter;
  logic               place_ok;
  logic [LetterW-1:0] rd_a;
  logic [LetterW-1:0] rd_b;
  logic [LetterW-1:0] idx1;
  logic [LetterW-1:0] idx2;

  assign in_a = norm_letter(item.first_letter);
  assign in_b = norm_letter(item.second_letter);

  assign place_letter = cmd.key_write ? in_a : walk;
  assign place_ok     = (cmd.key_write || (cmd.fill_step && (walk != LetterJ))) &&
                        !used[place_letter] && (fill_count < CellsCode);

  assign stat.complete  = complete;
  assign stat.fill_last = (walk == LetterZ);

  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      fill_count <= '0;
      fill_row   <= '0;
      fill_col   <= '0;
      complete   <= 1'b0;
    end else begin
      if (place_ok) begin
        used[place_letter] <= 1'b1;
        fill_count         <= fill_count + 5'd1;
        if (fill_col == SideLast) begin
          fill_col <= '0;
          fill_row <= fill_row + 3'd1;
        end else begin
          fill_col <= fill_col + 3'd1;
        end
      end
      if (cmd.fill_step && stat.fill_last) begin
        complete <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (place_ok) begin
      sq_mem[fill_count]    <= place_letter;
      pos_mem[place_letter] <= '{row: fill_row, col: fill_col};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      walk  <= '0;
      a_lat <= in_a;
      b_lat <= in_b;
    end else if (cmd.fill_step) begin
      walk <= walk + 5'd1;
    end
  end

  assign rd_a = cmd.pos_read_in ? in_a : a_lat;
  assign rd_b = cmd.pos_read_in ? in_b : b_lat;

  always_ff @(posedge clk) begin
    if (cmd.pos_read_in || cmd.pos_read_lat) begin
      pos1 <= pos_mem[rd_a];
      pos2 <= pos_mem[rd_b];
    end
  end

  always_comb begin
    if (pos1.col == pos2.col) begin
      idx1 = cell_index(dec_wrap(pos1.row), pos1.col);
      idx2 = cell_index(dec_wrap(pos2.row), pos2.col);
    end else if (pos1.row == pos2.row) begin
      idx1 = cell_index(pos1.row, dec_wrap(pos1.col));
      idx2 = cell_index(pos2.row, dec_wrap(pos2.col));
    end else begin
      idx1 = cell_index(pos1.row, pos2.col);
      idx2 = cell_index(pos2.row, pos1.col);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cell_read) begin
      result.plain_first  <= sq_mem[idx1];
      result.plain_second <= sq_mem[idx2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.cell_read;
    end
  end

endmodule

// ----- sv/playfair_decrypt_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_decrypt_top
// Playfair decryptor: builds the key square, then decrypts letter pairs.
// ----------------------------------------------------------------------------
// Key letter: busy stays low, so the next item may follow in the next cycle.
// Pair with square complete: positions read at transfer, then square read
// registers result and done strobe; busy during the square read, so a new
// pair waits for both. First pair: alphabet fill walk, then both reads.
// Synchronous reset empties the square; the receiver cannot stall.
module playfair_decrypt_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  pf_dec_pkg::pf_in_t  item,
  output logic               done,
  output pf_dec_pkg::pf_out_t result
);
  import pf_dec_pkg::*;

  pf_cmd_t  cmd;
  pf_stat_t stat;

  pf_dec_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (item.mode),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  pf_dec_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .done   (done),
    .result (result)
  );

endmodule

// ----- sv/pf_dec_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pf_dec_chk
// Port-level checks for the Playfair decryptor.
// ----------------------------------------------------------------------------
module pf_dec_chk (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input pf_dec_pkg::pf_in_t  item,
  input logic               done,
  input pf_dec_pkg::pf_out_t result
);
  import pf_dec_pkg::*;

  a_key_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (item.mode == MODE_KEY)) |=> !busy)
    else $error("key letter transfer left the block busy");

  a_done_spaced: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without prior work");

  a_plain_letter: assert property (@(posedge clk) disable iff (rst)
    done |-> ((result.plain_first <= LetterZ) && (result.plain_first != LetterJ) &&
              (result.plain_second <= LetterZ) && (result.plain_second != LetterJ)))
    else $error("result letter outside the square alphabet");

endmodule

bind playfair_decrypt_top pf_dec_chk u_pf_dec_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Playfair decryptor. Builds one key square from
// key letters (folded J, repeats, saturated codes), then decrypts directed and
// random cipher pairs while a local model of the square predicts every result.
// ----------------------------------------------------------------------------
module tb_top;
  import pf_dec_pkg::*;

  localparam int unsigned QuietLimit = 400;
  localparam int unsigned TotalItems = 1450;

  class plain_pair_board;
    logic [LetterW-1:0] grid[Cells];
    int unsigned        grid_row[Alpha];
    int unsigned        grid_col[Alpha];
    logic [Alpha-1:0]   placed;
    int unsigned        filled;
    bit                 sealed;
    pf_out_t            expected_plain[$];
    int unsigned        mismatches;
    int unsigned        pairs_checked;
    int unsigned        keys_placed;
    int unsigned        col_hits;
    int unsigned        row_hits;
    int unsigned        box_hits;

    function new();
      placed = '0;
      filled = 0;
      sealed = 0;
      mismatches = 0;
      pairs_checked = 0;
      keys_placed = 0;
      col_hits = 0;
      row_hits = 0;
      box_hits = 0;
    endfunction

    function logic [LetterW-1:0] canon(input logic [LetterW-1:0] l);
      logic [LetterW-1:0] v;
      v = l;
      if (v > LetterZ) begin
        v = LetterZ;
      end
      if (v == LetterJ) begin
        v = LetterI;
      end
      return v;
    endfunction

    function void place(input logic [LetterW-1:0] l);
      if (filled >= Cells || placed[l]) begin
        return;
      end
      grid[filled] = l;
      grid_row[l] = filled / Side;
      grid_col[l] = filled % Side;
      placed[l] = 1'b1;
      filled++;
    endfunction

    function void note(input pf_in_t it);
      int unsigned        r1, c1, r2, c2;
      int                 l;
      logic [LetterW-1:0] a, b;
      pf_out_t            p;
      if (it.mode == MODE_KEY) begin
        if (!sealed) begin
          if (!placed[canon(it.first_letter)] && filled < Cells) begin
            keys_placed++;
          end
          place(canon(it.first_letter));
        end
        return;
      end
      if (!sealed) begin
        for (l = 0; l < Alpha; l++) begin
          if (l != LetterJ) begin
            place(LetterW'(l));
          end
        end
        sealed = 1'b1;
      end
      a = canon(it.first_letter);
      b = canon(it.second_letter);
      r1 = grid_row[a];
      c1 = grid_col[a];
      r2 = grid_row[b];
      c2 = grid_col[b];
      if (c1 == c2) begin
        p.plain_first  = grid[((r1 + Side - 1) % Side) * Side + c1];
        p.plain_second = grid[((r2 + Side - 1) % Side) * Side + c2];
        col_hits++;
      end else if (r1 == r2) begin
        p.plain_first  = grid[r1 * Side + (c1 + Side - 1) % Side];
        p.plain_second = grid[r2 * Side + (c2 + Side - 1) % Side];
        row_hits++;
      end else begin
        p.plain_first  = grid[r1 * Side + c2];
        p.plain_second = grid[r2 * Side + c1];
        box_hits++;
      end
      expected_plain = {expected_plain, p};
    endfunction

    function void check(input pf_out_t got);
      pf_out_t want;
      if (expected_plain.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%t: result %0d,%0d with no pair pending", $realtime,
                   got.plain_first, got.plain_second);
        end
        return;
      end
      want = expected_plain.pop_front();
      pairs_checked++;
      if (got.plain_first !== want.plain_first ||
          got.plain_second !== want.plain_second) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%t: plain pair mismatch: expected %0d,%0d got %0d,%0d", $realtime,
                   want.plain_first, want.plain_second,
                   got.plain_first, got.plain_second);
        end
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  logic            busy;
  pf_in_t          item = '0;
  logic            done;
  pf_out_t         result;

  plain_pair_board board;
  bit              calm = 1'b0;
  int unsigned     transfers = 0;
  int unsigned     quiet_cycles = 0;
  int unsigned     pairs_sent = 0;
  int unsigned     keys_sent = 0;

  always #5 clk = ~clk;

  playfair_decrypt_top dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        board.check(result);
      end
      if (start && !busy) begin
        board.note(item);
        transfers++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%t: watchdog expired, %0d pairs still pending", $realtime,
               board.expected_plain.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic pf_in_t make_item(input logic m, input logic [LetterW-1:0] a,
                                       input logic [LetterW-1:0] b);
    pf_in_t it;
    it.mode = m;
    it.first_letter = a;
    it.second_letter = b;
    return it;
  endfunction

  function automatic logic [LetterW-1:0] pick_letter();
    if ($urandom_range(99) < 10) begin
      return LetterW'($urandom_range(31, 26));
    end
    return LetterW'($urandom_range(25));
  endfunction

  task automatic send(input pf_in_t it);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 23) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    item <= it;
    if (it.mode == MODE_KEY) begin
      keys_sent++;
    end else begin
      pairs_sent++;
    end
    do begin
      @(posedge clk);
    end while (busy);
  endtask

  initial begin
    logic [LetterW-1:0] a;
    board = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // key: P L A Y F, repeated A, J folded into I, I again, R, saturated codes
    send(make_item(MODE_KEY, 5'd15, 5'd31));
    send(make_item(MODE_KEY, 5'd11, 5'd0));
    send(make_item(MODE_KEY, 5'd0, 5'd17));
    send(make_item(MODE_KEY, 5'd24, 5'd9));
    send(make_item(MODE_KEY, 5'd5, 5'd26));
    send(make_item(MODE_KEY, 5'd0, 5'd0));
    send(make_item(MODE_KEY, LetterJ, 5'd30));
    send(make_item(MODE_KEY, LetterI, 5'd1));
    send(make_item(MODE_KEY, 5'd17, 5'd2));
    send(make_item(MODE_KEY, 5'd31, 5'd4));
    send(make_item(MODE_KEY, 5'd26, 5'd8));
    // first pair completes the square; then row, column, box, wrap, J, equal
    send(make_item(MODE_PAIR, 5'd15, 5'd11));
    send(make_item(MODE_PAIR, 5'd15, LetterI));
    send(make_item(MODE_PAIR, 5'd0, 5'd6));
    send(make_item(MODE_PAIR, 5'd25, 5'd25));
    send(make_item(MODE_PAIR, LetterJ, 5'd17));
    send(make_item(MODE_PAIR, 5'd31, 5'd0));
    send(make_item(MODE_PAIR, 5'd3, 5'd23));
    send(make_item(MODE_PAIR, 5'd5, 5'd19));
    send(make_item(MODE_PAIR, 5'd23, 5'd19));
    send(make_item(MODE_PAIR, 5'd19, 5'd15));
    send(make_item(MODE_KEY, 5'd4, 5'd21));
    send(make_item(MODE_KEY, LetterJ, 5'd10));
    send(make_item(MODE_PAIR, 5'd30, LetterJ));

    while (keys_sent + pairs_sent < TotalItems) begin
      calm = (pairs_sent >= 500 && pairs_sent < 800);
      if ($urandom_range(99) < 8) begin
        send(make_item(MODE_KEY, LetterW'($urandom_range(31)), LetterW'($urandom_range(31))));
      end else begin
        a = pick_letter();
        if ($urandom_range(99) < 5) begin
          send(make_item(MODE_PAIR, a, a));
        end else begin
          send(make_item(MODE_PAIR, a, pick_letter()));
        end
      end
    end
    calm = 1'b0;
    @(negedge clk);
    start <= 1'b0;

    while (board.expected_plain.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);

    $display("%0d transfers (%0d key letters, %0d placed), %0d plain pairs checked",
             transfers, keys_sent, board.keys_placed, board.pairs_checked);
    $display("pair cases: %0d same column, %0d same row, %0d rectangle; %0d mismatches",
             board.col_hits, board.row_hits, board.box_hits, board.mismatches);
    if (board.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/pf_dec_pkg.sv
sv/pf_dec_ctrl.sv
sv/pf_dec_dp.sv
sv/playfair_decrypt_top.sv
sv/pf_dec_chk.sv
tb/tb_top.sv
